// ----- design/pprc_pkg.sv -----
// pprc_pkg: shared constants, register codes and the sequencer control bundle
// for the pulse peak rate counter. No dependencies.

package pprc_pkg;

    // Default sizing
    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 12;

    // Register and field widths
    localparam int WLEN_W     = 9;
    localparam int SKIP_W     = 8;
    localparam int RATIO_W    = 9;
    localparam int BPM_W      = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int PEAK_W     = 8;
    localparam int BPM_OUT_W  = 15;
    localparam int RATIO_FRAC = 8;   // Q1.8 threshold ratio

    localparam int MIN_WINDOW = 3;

    // Register reset values
    localparam logic [WLEN_W-1:0]  WLEN_RST  = WLEN_W'(250);
    localparam logic [SKIP_W-1:0]  SKIP_RST  = SKIP_W'(12);
    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(77);
    localparam logic [BPM_W-1:0]   BPM_RST   = BPM_W'(12);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH   = 2'd0,
        CFG_SKIP_AFTER_PEAK = 2'd1,
        CFG_THRESHOLD_RATIO = 2'd2,
        CFG_BPM_PER_PEAK    = 2'd3
    } cfg_idx_t;

    // Sequencer to datapath/top control
    typedef struct packed {
        logic in_rdy;     // collecting samples
        logic ld;         // store sample, accumulate sum
        logic clr_sum;    // drop running sum
        logic sm_start;   // smoothing pass begins
        logic sm_mul;     // N * x
        logic sm_diff;    // d = N*x - S
        logic s_wr;       // write a smoothed value
        logic s_first;    // smoothed index 0 (end sample)
        logic s_last;     // smoothed index N-1 (end sample)
        logic thr_ld;     // latch threshold, reset peak state
        logic pk_step;    // one peak scan step
        logic pk_center;  // scan window holds a full triple
        logic fin;        // window done, load result
    } ctrl_t;

endpackage

// ----- design/pprc_seq.sv -----
// pprc_seq: sequencer for the pulse peak rate counter. Runs sample collection,
// the smoothing pass, threshold setup and the peak scan. Depends on pprc_pkg.

module pprc_seq
    import pprc_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    localparam int NB = $clog2(MAX_WINDOW + 1),
    localparam int AW = $clog2(MAX_WINDOW)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [NB-1:0] n,
    input  logic          in_accept,
    input  logic          wlen_wr,
    input  logic          out_free,
    output ctrl_t         ctrl,
    output logic [AW-1:0] fill_addr,
    output logic [AW-1:0] x_raddr,
    output logic [AW-1:0] s_waddr,
    output logic [AW-1:0] s_raddr,
    output logic [AW-1:0] pk_idx
);

    typedef enum logic [8:0] {
        ST_LOAD    = 9'b000000001,
        ST_SM_RD0  = 9'b000000010,
        ST_SM_MUL  = 9'b000000100,
        ST_SM_DIFF = 9'b000001000,
        ST_SM_SUM  = 9'b000010000,
        ST_SM_END  = 9'b000100000,
        ST_THR     = 9'b001000000,
        ST_PK_EVAL = 9'b010000000,
        ST_FIN     = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          last_idx;

    assign last_idx = (NB'(idx_reg) == (n - NB'(1)));

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                ctrl.in_rdy = 1'b1;
                if (wlen_wr)
                begin
                    fill_next    = '0;
                    ctrl.clr_sum = 1'b1;
                end
                else if (in_accept)
                begin
                    ctrl.ld = 1'b1;
                    if ((NB'(fill_reg) + NB'(1)) == n)
                    begin
                        fill_next  = '0;
                        idx_next   = '0;
                        state_next = ST_SM_RD0;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_SM_RD0:
            begin
                ctrl.sm_start = 1'b1;
                state_next    = ST_SM_MUL;
            end
            ST_SM_MUL:
            begin
                ctrl.sm_mul = 1'b1;
                state_next  = ST_SM_DIFF;
            end
            ST_SM_DIFF:
            begin
                ctrl.sm_diff = 1'b1;
                state_next   = ST_SM_SUM;
            end
            ST_SM_SUM:
            begin
                // writes s[idx-1] once d[idx] is known
                ctrl.s_wr    = (idx_reg != '0);
                ctrl.s_first = (idx_reg == AW'(1));
                if (last_idx)
                begin
                    state_next = ST_SM_END;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SM_MUL;
                end
            end
            ST_SM_END:
            begin
                ctrl.s_wr   = 1'b1;
                ctrl.s_last = 1'b1;
                state_next  = ST_THR;
            end
            ST_THR:
            begin
                ctrl.thr_ld = 1'b1;
                idx_next    = '0;
                state_next  = ST_PK_EVAL;
            end
            ST_PK_EVAL:
            begin
                ctrl.pk_step   = 1'b1;
                ctrl.pk_center = (NB'(idx_reg) >= NB'(2));
                if (last_idx)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ctrl.fin     = 1'b1;
                    ctrl.clr_sum = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Read address runs one ahead in the states that prefetch the next entry
    assign fill_addr = fill_reg;
    assign x_raddr   = (state_reg == ST_SM_SUM) ? (idx_reg + 1'b1) : idx_reg;
    assign s_waddr   = (state_reg == ST_SM_END) ? idx_reg : (idx_reg - 1'b1);
    assign s_raddr   = (state_reg == ST_PK_EVAL) ? (idx_reg + 1'b1) : '0;
    assign pk_idx    = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- design/pprc_dp.sv -----
// pprc_dp: datapath of the pulse peak rate counter: sample and smoothed
// stores, the multiply and add steps, window max and peak scan. Uses pprc_pkg.

module pprc_dp
    import pprc_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int NB   = $clog2(MAX_WINDOW + 1),
    localparam int AW   = $clog2(MAX_WINDOW),
    localparam int CNTW = (NB > PEAK_W) ? NB : PEAK_W
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_t                  ctrl,
    input  logic [NB-1:0]          n,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [AW-1:0]          fill_addr,
    input  logic [AW-1:0]          x_raddr,
    input  logic [AW-1:0]          s_waddr,
    input  logic [AW-1:0]          s_raddr,
    input  logic [AW-1:0]          pk_idx,
    input  logic [SKIP_W-1:0]      skip,
    input  logic [RATIO_W-1:0]     ratio,
    output logic [CNTW-1:0]        cnt
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = NB + SB;            // N*x and window sum
    localparam int DW = PW + 1;             // mean-removed sample, signed
    localparam int SW = DW + 2;             // 3-point sum, signed
    localparam int TW = SW - 1 + RATIO_W;   // threshold product
    localparam int CW = ((NB > SKIP_W) ? NB : SKIP_W) + 1;

    logic [SB-1:0]        x_mem [MAX_WINDOW];
    logic [SB-1:0]        x_q_reg;
    logic signed [SW-1:0] s_mem [MAX_WINDOW];
    logic signed [SW-1:0] s_q_reg;

    logic [PW-1:0]        sum_reg;
    logic [PW-1:0]        p_reg;
    logic signed [DW-1:0] d0_reg, d1_reg, d2_reg;
    logic signed [DW-1:0] d_new;
    logic signed [SW-1:0] e0, e1, e2, sel, tri_v, sum3, s_val;
    logic signed [SW-1:0] m_reg;
    logic [TW-1:0]        thr_reg;
    logic signed [SW-1:0] q0_reg, q1_reg;
    logic [CW-1:0]        cand_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [TW-1:0]        lhs;
    logic [CW-1:0]        ctr_idx;
    logic                 above;
    logic                 is_peak;

    // Sample store
    always_ff @(posedge clk)
    begin
        if (ctrl.ld)
        begin
            x_mem[fill_addr] <= sample;
        end
        x_q_reg <= x_mem[x_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.clr_sum)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.ld)
        begin
            sum_reg <= sum_reg + PW'(sample);
        end
    end

    // d[i] = N*x[i] - S, then the 3-point sum (3*d at both ends)
    assign d_new = signed'({1'b0, p_reg}) - signed'({1'b0, sum_reg});
    assign e0    = SW'(d0_reg);
    assign e1    = SW'(d1_reg);
    assign e2    = SW'(d2_reg);
    assign sel   = ctrl.s_last ? e0 : e1;
    assign tri_v = sel + (sel <<< 1);
    assign sum3  = e0 + e1 + e2;
    assign s_val = (ctrl.s_first || ctrl.s_last) ? tri_v : sum3;

    always_ff @(posedge clk)
    begin
        if (ctrl.sm_mul)
        begin
            p_reg <= PW'(n) * PW'(x_q_reg);
        end
        if (ctrl.sm_diff)
        begin
            d0_reg <= d_new;
            d1_reg <= d0_reg;
            d2_reg <= d1_reg;
        end
        if (ctrl.sm_start)
        begin
            m_reg <= '0;
        end
        else if (ctrl.s_wr && (s_val > m_reg))
        begin
            m_reg <= s_val;
        end
    end

    // Smoothed store
    always_ff @(posedge clk)
    begin
        if (ctrl.s_wr)
        begin
            s_mem[s_waddr] <= s_val;
        end
        s_q_reg <= s_mem[s_raddr];
    end

    // Peak scan: q1 = s[j-2], q0 = s[j-1] (center), s_q_reg = s[j]
    assign lhs     = TW'({q0_reg[SW-2:0], {RATIO_FRAC{1'b0}}});
    assign above   = !q0_reg[SW-1] && (lhs > thr_reg);
    assign ctr_idx = CW'(pk_idx) - CW'(1);
    assign is_peak = ctrl.pk_center && (ctr_idx >= cand_reg) &&
                     (q0_reg > q1_reg) && (q0_reg > s_q_reg) && above;

    always_ff @(posedge clk)
    begin
        if (ctrl.thr_ld)
        begin
            thr_reg  <= TW'(m_reg[SW-2:0]) * TW'(ratio);
            cnt_reg  <= '0;
            cand_reg <= CW'(1);
        end
        else if (ctrl.pk_step)
        begin
            q1_reg <= q0_reg;
            q0_reg <= s_q_reg;
            if (is_peak)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                cand_reg <= ctr_idx + CW'(skip) + CW'(1);
            end
        end
    end

    assign cnt = cnt_reg;

endmodule

// ----- design/pulse_peak_rate_counter_core.sv -----
// pulse_peak_rate_counter_core: top level of the pulse peak rate counter.
// Holds the configuration registers and result register; uses pprc_pkg,
// pprc_seq and pprc_dp.

// The block takes one ADC sample per accepted item until a window of N samples
// is in, N being window_length clamped to 3..MAX_WINDOW. It then stalls its
// input while it processes the window: a smoothing pass that takes each sample
// through a sample store read, an N*x multiply, a mean subtract and a 3-point
// add, a threshold setup step, a peak scan over the smoothed store one sample
// per step, and a final step that loads the result once the output register
// is free. Each store has a single read port. Results are one item per window
// (peak count and count times bpm_per_peak) in an output register, so the next
// window can start filling while a result waits. Writing window_length drops a
// partial window.

module pulse_peak_rate_counter_core
    import pprc_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample items
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    // result items
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PEAK_W-1:0]      peak_total,
    output logic [BPM_OUT_W-1:0]   beats_per_minute,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int NB   = $clog2(MAX_WINDOW + 1);
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int CNTW = (NB > PEAK_W) ? NB : PEAK_W;
    localparam int LW   = (NB > WLEN_W) ? NB : WLEN_W;
    localparam int PRW  = CNTW + BPM_W;

    logic [WLEN_W-1:0]    wlen_reg;
    logic [SKIP_W-1:0]    skip_reg;
    logic [RATIO_W-1:0]   ratio_reg;
    logic [BPM_W-1:0]     bpm_reg;

    logic                 out_valid_reg;
    logic [PEAK_W-1:0]    peak_total_reg;
    logic [BPM_OUT_W-1:0] bpm_out_reg;

    logic                 wlen_wr;
    logic [LW-1:0]        wlen_ext;
    logic [LW-1:0]        n_ext;
    logic [NB-1:0]        n;
    logic                 in_accept;
    logic                 out_free;
    ctrl_t                ctrl;
    logic [AW-1:0]        fill_addr, x_raddr, s_waddr, s_raddr, pk_idx;
    logic [CNTW-1:0]      cnt;
    logic [PRW-1:0]       bpm_prod;

    // Configuration registers
    assign wlen_wr = cfg_we && (cfg_idx_t'(cfg_index) == CFG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg  <= WLEN_RST;
            skip_reg  <= SKIP_RST;
            ratio_reg <= RATIO_RST;
            bpm_reg   <= BPM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LENGTH:   wlen_reg  <= cfg_wdata[WLEN_W-1:0];
                CFG_SKIP_AFTER_PEAK: skip_reg  <= cfg_wdata[SKIP_W-1:0];
                CFG_THRESHOLD_RATIO: ratio_reg <= cfg_wdata[RATIO_W-1:0];
                CFG_BPM_PER_PEAK:    bpm_reg   <= cfg_wdata[BPM_W-1:0];
            endcase
        end
    end

    // Effective window length
    assign wlen_ext = LW'(wlen_reg);

    always_comb
    begin
        priority if (wlen_ext < LW'(MIN_WINDOW))
        begin
            n_ext = LW'(MIN_WINDOW);
        end
        else if (wlen_ext > LW'(MAX_WINDOW))
        begin
            n_ext = LW'(MAX_WINDOW);
        end
        else
        begin
            n_ext = wlen_ext;
        end
    end

    assign n = NB'(n_ext);

    // Handshakes
    assign in_stall  = !ctrl.in_rdy;
    assign in_accept = in_valid && ctrl.in_rdy;
    assign out_free  = !out_valid_reg || !out_stall;

    pprc_seq #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n),
        .in_accept (in_accept),
        .wlen_wr   (wlen_wr),
        .out_free  (out_free),
        .ctrl      (ctrl),
        .fill_addr (fill_addr),
        .x_raddr   (x_raddr),
        .s_waddr   (s_waddr),
        .s_raddr   (s_raddr),
        .pk_idx    (pk_idx)
    );

    pprc_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .n         (n),
        .sample    (sample),
        .fill_addr (fill_addr),
        .x_raddr   (x_raddr),
        .s_waddr   (s_waddr),
        .s_raddr   (s_raddr),
        .pk_idx    (pk_idx),
        .skip      (skip_reg),
        .ratio     (ratio_reg),
        .cnt       (cnt)
    );

    // Result register
    assign bpm_prod = PRW'(cnt) * PRW'(bpm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin)
        begin
            peak_total_reg <= cnt[PEAK_W-1:0];
            bpm_out_reg    <= bpm_prod[BPM_OUT_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign peak_total       = peak_total_reg;
    assign beats_per_minute = bpm_out_reg;

endmodule

// ----- test/pprc_window_checker.sv -----
// pprc_window_checker: watches the sample, result and configuration ports of the
// pulse peak rate counter, predicts each window result and compares it.
// Depends on pprc_pkg for widths, reset values and register codes.

module pprc_window_checker
    import pprc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [SAMPLE_BITS_DEF-1:0] sample,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [PEAK_W-1:0]          peak_total,
    input  logic [BPM_OUT_W-1:0]       beats_per_minute,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    output int                         mismatches,
    output int                         results_pending,
    output int                         windows_seen
);

    typedef struct packed {
        logic [PEAK_W-1:0]    peaks;
        logic [BPM_OUT_W-1:0] bpm;
    } window_result_t;

    // shadow registers
    logic [WLEN_W-1:0]  wlen;
    logic [SKIP_W-1:0]  skip;
    logic [RATIO_W-1:0] ratio;
    logic [BPM_W-1:0]   bpm_step;

    logic [SAMPLE_BITS_DEF-1:0] window_samples [0:MAX_WINDOW_DEF-1];
    logic [19:0]                sample_sum;
    logic [8:0]                 filled;

    window_result_t results_due [$];
    int             n_bad = 0;
    int             n_windows = 0;

    assign mismatches   = n_bad;
    assign windows_seen = n_windows;

    function automatic int unsigned active_length();
        if (wlen < MIN_WINDOW)
            return MIN_WINDOW;
        if (wlen > MAX_WINDOW_DEF)
            return MAX_WINDOW_DEF;
        return wlen;
    endfunction

    // Mean removal and 3-point sum, both scaled so that everything stays integer.
    function automatic logic [PEAK_W-1:0] count_peaks(input int unsigned n);
        logic signed [24:0] dev    [0:MAX_WINDOW_DEF-1];
        logic signed [24:0] smooth [0:MAX_WINDOW_DEF-1];
        logic signed [24:0] len_s;
        logic signed [24:0] sum_s;
        logic signed [24:0] top;
        logic signed [40:0] thr;
        logic signed [40:0] scaled;
        logic [PEAK_W-1:0]  found;
        int unsigned        i;
        len_s = 25'(n);
        sum_s = {5'd0, sample_sum};
        for (i = 0; i < n; i++)
            dev[i] = len_s * $signed({13'd0, window_samples[i]}) - sum_s;
        for (i = 0; i < n; i++)
        begin
            if (i == 0 || i + 1 == n)
                smooth[i] = dev[i] + dev[i] + dev[i];
            else
                smooth[i] = dev[i-1] + dev[i] + dev[i+1];
        end
        top = '0;
        for (i = 0; i < n; i++)
            if (smooth[i] > top)
                top = smooth[i];
        thr = top * $signed({1'b0, ratio});
        found = '0;
        i = 1;
        while (i + 1 < n)
        begin
            scaled = smooth[i];
            if (smooth[i] > smooth[i-1] && smooth[i] > smooth[i+1] && (scaled <<< 8) > thr)
            begin
                found++;
                i += skip + 1;
            end
            else
                i++;
        end
        return found;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        n_bad++;
        $display("mismatch at result %0d: %s got %0d, want %0d", n_windows, what, got_v, want_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        window_result_t        want;
        logic [PEAK_W-1:0]     peaks;
        logic [BPM_OUT_W-1:0]  beats;
        if (!rst_n)
        begin
            wlen       = WLEN_RST;
            skip       = SKIP_RST;
            ratio      = RATIO_RST;
            bpm_step   = BPM_RST;
            sample_sum = '0;
            filled     = '0;
            results_due.delete();
            results_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected result, peak_total", peak_total, -1);
                else
                begin
                    want = results_due.pop_front();
                    if (peak_total !== want.peaks)
                        report_mismatch("peak_total", peak_total, want.peaks);
                    if (beats_per_minute !== want.bpm)
                        report_mismatch("beats_per_minute", beats_per_minute, want.bpm);
                end
                n_windows++;
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WINDOW_LENGTH:
                    begin
                        // a new length drops the partial window
                        wlen       = cfg_wdata;
                        filled     = '0;
                        sample_sum = '0;
                    end
                    CFG_SKIP_AFTER_PEAK: skip     = cfg_wdata[SKIP_W-1:0];
                    CFG_THRESHOLD_RATIO: ratio    = cfg_wdata;
                    CFG_BPM_PER_PEAK:    bpm_step = cfg_wdata[BPM_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                window_samples[filled[7:0]] = sample;
                sample_sum += sample;
                filled++;
                if (filled >= active_length())
                begin
                    peaks = count_peaks(active_length());
                    beats = peaks * bpm_step;
                    results_due.push_back('{peaks: peaks, bpm: beats});
                    filled     = '0;
                    sample_sum = '0;
                end
            end
            results_pending <= results_due.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// tb: stimulus and verdict for pulse_peak_rate_counter_core.
// Depends on pprc_pkg, the core and pprc_window_checker, which does all checking.

module tb
    import pprc_pkg::*;
();

    localparam int SAMPLE_TARGET = 1350;
    // drain wait, sized for a loaded window of MAX_WINDOW samples to be processed
    localparam int DRAIN_CYCLES  = 5 * MAX_WINDOW_DEF + 120;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;
    typedef enum int {SHAPE_PULSE, SHAPE_NOISE, SHAPE_RAIL, SHAPE_FLAT} shape_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [SAMPLE_BITS_DEF-1:0] sample    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [PEAK_W-1:0]          peak_total;
    logic [BPM_OUT_W-1:0]       beats_per_minute;
    logic                       cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

    int mismatches;
    int results_pending;
    int windows_seen;
    int items_sent = 0;
    int cycles     = 0;

    // traffic pattern and waveform of the current phase
    flow_t  flow = FLOW_FREE;
    shape_t shape = SHAPE_PULSE;
    int     pulse_period = 8;
    int     pulse_width  = 2;
    int     level        = 0;
    int     swing        = 0;
    int     jitter       = 0;

    pulse_peak_rate_counter_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .peak_total       (peak_total),
        .beats_per_minute (beats_per_minute),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    pprc_window_checker watcher (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .peak_total       (peak_total),
        .beats_per_minute (beats_per_minute),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .results_pending  (results_pending),
        .windows_seen     (windows_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decide an idle cycle for the sender (sink = 0) or a stall for the receiver.
    function automatic bit hold_off(input flow_t f, input bit sink);
        case (f)
            FLOW_SRC_GAPS:    return !sink && $urandom_range(99) < 78;
            FLOW_SINK_STALLS: return sink && $urandom_range(99) < 78;
            FLOW_BOTH:        return $urandom_range(99) < 14;
            default:          return 1'b0;
        endcase
    endfunction

    // Receiver side: stall is redrawn every cycle, so stalls land on any phase
    // of the block's work, including while it crunches a window.
    always @(posedge clk)
        out_stall <= hold_off(flow, 1'b1);

    // Pulse trains are the well-formed case: a baseline, a decaying bump every
    // period and a bit of noise, so there are real maxima to find. The other
    // shapes are raw noise, random rail-to-rail values and a flat line.
    function automatic logic [SAMPLE_BITS_DEF-1:0] next_sample(input int k);
        int v;
        int ph;
        case (shape)
            SHAPE_NOISE: v = $urandom_range(4095);
            SHAPE_RAIL:  v = $urandom_range(1) ? 4095 : 0;
            SHAPE_FLAT:  v = level;
            default:
            begin
                ph = k % pulse_period;
                v  = level + $urandom_range(jitter);
                if (ph < pulse_width)
                    v += swing - (swing * ph) / pulse_width;
            end
        endcase
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_BITS_DEF-1:0];
    endfunction

    // One item: optional idle cycles with valid low, then hold valid and the
    // sample until the block takes it.
    task automatic send_sample(input int value);
        while (hold_off(flow, 1'b0))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= SAMPLE_BITS_DEF'(value);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending, wait for every outstanding result, then give the block
    // time to finish any window it may still be chewing on.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Hard stop if the block hangs or loses a result.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int r;
        int wl;
        int n_len;
        int windows;
        int count;
        int k;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed cases ----
        // Length 0 clamps to 3. With three samples the centre sum is always
        // zero, so the window max stays 0 and nothing counts.
        write_reg(CFG_WINDOW_LENGTH, 0);
        write_reg(CFG_SKIP_AFTER_PEAK, 0);
        write_reg(CFG_THRESHOLD_RATIO, 77);
        write_reg(CFG_BPM_PER_PEAK, 255);
        send_sample(0);
        send_sample(4095);
        send_sample(0);
        settle();

        // flat window at full scale, length 2 also clamps to 3
        write_reg(CFG_WINDOW_LENGTH, 2);
        send_sample(4095);
        send_sample(4095);
        send_sample(4095);
        settle();

        // length 4 with a shoulder: one peak at index 1, max bpm step
        write_reg(CFG_WINDOW_LENGTH, 4);
        send_sample(2000);
        send_sample(4095);
        send_sample(4095);
        send_sample(0);
        settle();

        // same window, ratio above one: nothing can clear the threshold
        write_reg(CFG_THRESHOLD_RATIO, 300);
        send_sample(2000);
        send_sample(4095);
        send_sample(4095);
        send_sample(0);
        settle();

        // partial window, then a length write that must drop it
        write_reg(CFG_WINDOW_LENGTH, 5);
        send_sample(100);
        send_sample(200);
        settle();
        write_reg(CFG_WINDOW_LENGTH, 7);
        write_reg(CFG_THRESHOLD_RATIO, 0);
        write_reg(CFG_BPM_PER_PEAK, 1);
        for (k = 0; k < 7; k++)
            send_sample((k % 2) ? 4095 : 0);
        settle();

        // ---- random phases ----
        // Each phase picks a fresh setting, traffic pattern and waveform. Most
        // windows are short so results come often; a few use the largest size.
        phase = 0;
        while (items_sent < SAMPLE_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 4)
                wl = $urandom_range(1) ? MAX_WINDOW_DEF : $urandom_range(511, 257);
            else if (r < 10)
                wl = $urandom_range(2);
            else
                wl = $urandom_range(40, 3);
            write_reg(CFG_WINDOW_LENGTH, wl);

            r = $urandom_range(99);
            write_reg(CFG_SKIP_AFTER_PEAK,
                      (r < 15) ? 0 : (r < 25) ? 255 : $urandom_range(24));

            r = $urandom_range(99);
            write_reg(CFG_THRESHOLD_RATIO,
                      (r < 10) ? 0 : (r < 15) ? 256 :
                      (r < 22) ? $urandom_range(511, 257) : $urandom_range(220, 30));

            r = $urandom_range(99);
            write_reg(CFG_BPM_PER_PEAK,
                      (r < 10) ? 0 : (r < 20) ? 255 : $urandom_range(255));

            r = $urandom_range(99);
            shape        = (r < 60) ? SHAPE_PULSE : (r < 78) ? SHAPE_NOISE :
                           (r < 90) ? SHAPE_RAIL : SHAPE_FLAT;
            pulse_period = $urandom_range(24, 2);
            pulse_width  = $urandom_range(pulse_period, 1);
            level        = (shape == SHAPE_FLAT) ? $urandom_range(4095) : $urandom_range(2500);
            swing        = $urandom_range(1595);
            jitter       = $urandom_range(300);
            flow         = flow_t'(phase % 4);

            n_len   = (wl < MIN_WINDOW) ? MIN_WINDOW : (wl > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : wl;
            windows = (n_len > 64) ? 1 : $urandom_range(5, 1);
            // sometimes leave a partial window behind for the next length write
            count   = windows * n_len + (($urandom_range(3) == 0) ? $urandom_range(n_len - 1) : 0);
            for (k = 0; k < count; k++)
                send_sample(next_sample(k));
            settle();
            phase++;
        end

        $display("Run covered %0d sample items over %0d random phases plus directed cases,",
                 items_sent, phase);
        $display("with %0d window results compared under varied settings and traffic.",
                 windows_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
